[hw/rtl/nmea_pkg.sv]
package nmea_pkg;

  localparam int MAX_FIELD_CHARS = 16;
  localparam int CPOS_W          = $clog2(MAX_FIELD_CHARS + 1);

  // commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // field ids
  localparam logic [2:0] FID_UTC   = 3'd0;
  localparam logic [2:0] FID_LAT   = 3'd1;
  localparam logic [2:0] FID_NS    = 3'd2;
  localparam logic [2:0] FID_LON   = 3'd3;
  localparam logic [2:0] FID_EW    = 3'd4;
  localparam logic [2:0] FID_FIX   = 3'd5;
  localparam logic [2:0] FID_SATS  = 3'd6;
  localparam logic [2:0] FID_SPEED = 3'd7;

  // configuration register indexes
  localparam int         CFG_IDX_W        = 1;
  localparam int         CFG_DATA_W       = 16;
  localparam logic [0:0] CFG_IDLE_TIMEOUT = 1'b0;
  localparam logic [0:0] CFG_MAX_ATTEMPTS = 1'b1;

  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd1000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd25;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_V      = 8'h56;
  localparam logic [7:0] CH_T      = 8'h54;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] field_id;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic       success;
    logic       timed_out;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // expected header character after '$': "GPGGA," or "GPVTG,"
  function automatic logic [7:0] hdr_char(input logic is_gga, input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CH_G;
      3'd1:    c = CH_P;
      3'd2:    c = is_gga ? CH_G : CH_V;
      3'd3:    c = is_gga ? CH_G : CH_T;
      3'd4:    c = is_gga ? CH_A : CH_G;
      default: c = CH_COMMA;
    endcase
    return c;
  endfunction

endpackage

[hw/rtl/nmea_gga_vtg_field_extractor_top.sv]
// channel   signals                                  direction
// in        in_valid_i / in_ready_o / in_item_i      command + rx byte into block
// out       out_valid_o / out_ready_i / out_item_o   field character or finish
// cfg       cfg_we_i / cfg_idx_i / cfg_data_i        register write, no wait
//
// One request per cycle sustained while the result register is free; a request
// passes the input register, then the parser step into the result register.
// in_ready_o drops only while the input register is full and the result
// register holds an untaken result. Reset is asynchronous, active low, and
// restores the register defaults (timeout 1000 ticks, 25 attempts).
module nmea_gga_vtg_field_extractor_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [nmea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nmea_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  nmea_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nmea_pkg::out_item_t             out_item_o
);
  import nmea_pkg::*;

  logic     stage_valid;
  in_item_t stage_item;
  logic     out_free;
  logic     advance;
  result_t  res;

  assign advance = stage_valid && out_free;

  nmea_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  nmea_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (advance),
    .item_i     (stage_item),
    .res_o      (res)
  );

  nmea_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res.valid),
    .item_i      (res.item),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[hw/rtl/nmea_in_reg.sv]
module nmea_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  nmea_pkg::in_item_t in_item_i,
  input  logic               advance_i,
  output logic               valid_o,
  output nmea_pkg::in_item_t item_o
);
  import nmea_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_item_i;
    end
  end

endmodule

[hw/rtl/nmea_out_reg.sv]
module nmea_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  nmea_pkg::out_item_t item_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output nmea_pkg::out_item_t out_item_o
);
  import nmea_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

endmodule

[hw/rtl/nmea_parser.sv]
module nmea_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nmea_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nmea_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                step_i,
  input  nmea_pkg::in_item_t                  item_i,
  output nmea_pkg::result_t                   res_o
);
  import nmea_pkg::*;

  localparam logic [2:0] PH_SEEK_GGA  = 3'd0;
  localparam logic [2:0] PH_HDR_GGA   = 3'd1;
  localparam logic [2:0] PH_GGA_FIELD = 3'd2;
  localparam logic [2:0] PH_SEEK_VTG  = 3'd3;
  localparam logic [2:0] PH_HDR_VTG   = 3'd4;
  localparam logic [2:0] PH_VTG_SKIP  = 3'd5;
  localparam logic [2:0] PH_SPEED     = 3'd6;

  localparam logic [CPOS_W-1:0] CPOS_MAX = CPOS_W'(MAX_FIELD_CHARS);

  logic [15:0]       timeout_q;
  logic [7:0]        max_att_q;
  logic              busy_q, busy_d;
  logic [2:0]        phase_q, phase_d;
  logic [2:0]        hdr_q, hdr_d;
  logic [2:0]        fn_q, fn_d;
  logic [CPOS_W-1:0] cp_q, cp_d;
  logic [7:0]        att_q, att_d;
  logic [15:0]       idle_q, idle_d;
  logic [7:0]        fix_q, fix_d;
  logic              gga_q, gga_d;

  logic        do_end;
  logic        do_cap;
  logic [2:0]  cap_fid;
  logic [7:0]  rx;
  logic [2:0]  hp;
  logic        is_gga;
  logic        one_char;
  logic [15:0] idle_inc;
  result_t     res;

  always_comb begin
    busy_d   = busy_q;
    phase_d  = phase_q;
    hdr_d    = hdr_q;
    fn_d     = fn_q;
    cp_d     = cp_q;
    att_d    = att_q;
    idle_d   = idle_q;
    fix_d    = fix_q;
    gga_d    = gga_q;
    res      = '0;
    do_end   = 1'b0;
    do_cap   = 1'b0;
    cap_fid  = FID_UTC;
    rx       = item_i.rx_byte;
    hp       = (hdr_q < 3'd5) ? hdr_q : 3'd5;
    is_gga   = (phase_q == PH_HDR_GGA);
    one_char = (fn_q == FID_NS) || (fn_q == FID_EW) || (fn_q == FID_FIX);
    idle_inc = (idle_q != 16'hFFFF) ? idle_q + 16'd1 : idle_q;

    if (step_i) begin
      case (item_i.command)
        CMD_START: begin
          // a start while busy drops the running request silently
          busy_d = 1'b1;
          att_d  = '0;
          idle_d = '0;
          fix_d  = '0;
          gga_d  = 1'b0;
          if (max_att_q == 8'd0) begin
            busy_d         = 1'b0;
            res.valid      = 1'b1;
            res.item.kind  = KIND_DONE;
          end else begin
            att_d   = 8'd1;
            phase_d = PH_SEEK_GGA;
            hdr_d   = '0;
            fn_d    = '0;
            cp_d    = '0;
          end
        end
        CMD_BYTE: begin
          if (busy_q) begin
            idle_d = '0;
            case (phase_q)
              PH_SEEK_GGA, PH_SEEK_VTG: begin
                if (rx == CH_DOLLAR) begin
                  phase_d = (phase_q == PH_SEEK_GGA) ? PH_HDR_GGA : PH_HDR_VTG;
                  hdr_d   = '0;
                end
              end
              PH_HDR_GGA, PH_HDR_VTG: begin
                if (rx != hdr_char(is_gga, hp)) begin
                  if (is_gga) begin
                    phase_d = PH_SEEK_VTG;
                  end else begin
                    do_end = 1'b1;
                  end
                end else if (hp < 3'd5) begin
                  hdr_d = hp + 3'd1;
                end else begin
                  hdr_d   = '0;
                  fn_d    = '0;
                  cp_d    = '0;
                  phase_d = is_gga ? PH_GGA_FIELD : PH_VTG_SKIP;
                end
              end
              PH_GGA_FIELD: begin
                if (rx == CH_COMMA) begin
                  // empty fix field means no fix
                  if (fn_q == FID_FIX && cp_q == '0) begin
                    fix_d = CH_ZERO;
                  end
                  cp_d = '0;
                  if (fn_q >= FID_SATS) begin
                    gga_d   = 1'b1;
                    phase_d = PH_SEEK_VTG;
                    fn_d    = '0;
                  end else begin
                    fn_d = fn_q + 3'd1;
                  end
                end else if (!(one_char && cp_q != '0)) begin
                  if (fn_q == FID_FIX) begin
                    fix_d = rx;
                  end
                  do_cap  = 1'b1;
                  cap_fid = fn_q;
                end
              end
              PH_VTG_SKIP: begin
                if (rx == CH_COMMA) begin
                  if (fn_q >= 3'd5) begin
                    phase_d = PH_SPEED;
                    fn_d    = '0;
                    cp_d    = '0;
                  end else begin
                    fn_d = fn_q + 3'd1;
                  end
                end
              end
              PH_SPEED: begin
                if (rx == CH_COMMA) begin
                  do_end = 1'b1;
                end else begin
                  do_cap  = 1'b1;
                  cap_fid = FID_SPEED;
                end
              end
              default: begin
                phase_d = PH_SEEK_GGA;
              end
            endcase
          end
        end
        CMD_TICK: begin
          if (busy_q) begin
            idle_d = idle_inc;
            if (idle_inc >= timeout_q) begin
              busy_d             = 1'b0;
              res.valid          = 1'b1;
              res.item.kind      = KIND_DONE;
              res.item.timed_out = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end

    // end of one attempt: finish or retry
    if (do_end) begin
      if (gga_q) begin
        busy_d           = 1'b0;
        res.valid        = 1'b1;
        res.item.kind    = KIND_DONE;
        res.item.success = (att_q < max_att_q) && (fix_q != CH_ZERO);
      end else if (att_q >= max_att_q) begin
        busy_d        = 1'b0;
        res.valid     = 1'b1;
        res.item.kind = KIND_DONE;
      end else begin
        att_d   = (att_q != 8'hFF) ? att_q + 8'd1 : att_q;
        phase_d = PH_SEEK_GGA;
        hdr_d   = '0;
        fn_d    = '0;
        cp_d    = '0;
      end
    end

    // characters past the buffer depth are dropped
    if (do_cap && cp_q < CPOS_MAX) begin
      cp_d                = cp_q + CPOS_W'(1);
      res.valid           = 1'b1;
      res.item.kind       = KIND_CHAR;
      res.item.field_id   = cap_fid;
      res.item.char_index = 4'(cp_q);
      res.item.char_value = rx;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= IDLE_TIMEOUT_RST;
      max_att_q <= MAX_ATTEMPTS_RST;
      busy_q    <= 1'b0;
      phase_q   <= PH_SEEK_GGA;
      hdr_q     <= '0;
      fn_q      <= '0;
      cp_q      <= '0;
      att_q     <= '0;
      idle_q    <= '0;
      fix_q     <= '0;
      gga_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IDLE_TIMEOUT: timeout_q <= cfg_data_i;
          CFG_MAX_ATTEMPTS: max_att_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      busy_q  <= busy_d;
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      fn_q    <= fn_d;
      cp_q    <= cp_d;
      att_q   <= att_d;
      idle_q  <= idle_d;
      fix_q   <= fix_d;
      gga_q   <= gga_d;
    end
  end

`ifndef SYNTH
  a_busy_fall_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(res_o.valid && res_o.item.kind == KIND_DONE))
    else $error("request closed without a finish result");

  a_busy_rise_on_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> $past(step_i && item_i.command == CMD_START))
    else $error("request opened without a start");

  a_char_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.item.kind == KIND_CHAR |-> busy_q)
    else $error("character emitted outside a request");

  a_cpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_q <= CPOS_MAX)
    else $error("character position beyond buffer depth");
`endif

endmodule
